>>> sv/image_sharpen_3x3_cross_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the image_sharpen_3x3_cross block
// Each check is sampled on clk and switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMAGE_SHARPEN_3X3_CROSS_MACROS_SVH
`define IMAGE_SHARPEN_3X3_CROSS_MACROS_SVH
`ifndef SYNTH
`define ISS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iss implication check failed");
`define ISS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iss next-cycle check failed");
`else
`define ISS_ASSERT_IMPLY(lbl, ante, cons)
`define ISS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> sv/iss_pkg.sv
// ----------------------------------------------------------------------------
// iss_pkg
// Shared constants and types of the 3x3 cross sharpening block.
// ----------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_CHANNELS = 4;
  localparam int DEF_MAX_HEIGHT   = 4096;

  localparam int SAMPLE_W = 8;
  localparam int POS_W    = 12;

  localparam int IMAGE_WIDTH_W   = 11;
  localparam int IMAGE_HEIGHT_W  = 13;
  localparam int CHANNEL_COUNT_W = 3;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  localparam int RST_IMAGE_WIDTH   = 640;
  localparam int RST_IMAGE_HEIGHT  = 480;
  localparam int RST_CHANNEL_COUNT = 3;

  localparam int MIN_DIM      = 3;
  localparam int MIN_CHANNELS = 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  // One classified sample with its neighbourhood, ready for the back end.
  typedef struct packed {
    logic [SAMPLE_W-1:0] up;
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] lf;
    logic [SAMPLE_W-1:0] rt;
    logic [SAMPLE_W-1:0] dn;
    logic                interior;
    logic                last_row;
    logic                frame_end;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    index;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } q_wr_t;

endpackage

`default_nettype wire

>>> sv/image_sharpen_3x3_cross.sv
// ----------------------------------------------------------------------------
// image_sharpen_3x3_cross
// 3x3 cross sharpening of a channel-interleaved 8-bit raster stream.
// ----------------------------------------------------------------------------
// Samples enter on the in_ channel (in_push/in_full) in raster order, one
// beat per sample. Results leave on the out_ channel as a queue: the oldest
// result is shown while out_empty is low and is taken by out_pop. Results
// trail the input by one row: a beat of row 0 gives the zero for row 0, a
// beat of row 1 gives nothing, a beat of row r >= 2 gives the result for row
// r-1 at the same index, and a beat of the last row also gives that row's
// zero, flagged frame_end on the final sample.
// Throughput is one sample per cycle while in_full is low; a last-row beat
// gives its two results at the back end one after the other. An accepted beat
// passes through stage one and the queue into the out_ result register.
// The cfg_ channel is always ready; any write to a listed register restarts
// the frame at row 0. Reset loads 640 x 480 pixels, 3 channels, clears the
// counters and the queue; the line stores keep their contents.
// When the receiver stalls, a four-entry descriptor queue absorbs the front
// end's work; in_full rises once queue entries plus a stage-one beat fill it.
// ----------------------------------------------------------------------------
`default_nettype none

module image_sharpen_3x3_cross #(
  parameter int MAX_WIDTH    = iss_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = iss_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_HEIGHT   = iss_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [iss_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [iss_pkg::SAMPLE_W-1:0]   out_value,
  output logic [iss_pkg::POS_W-1:0]      out_row,
  output logic [iss_pkg::POS_W-1:0]      out_index,
  output logic                           out_frame_end,
  output logic                           out_run_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import iss_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int CEW = $clog2(MAX_CHANNELS + 1);

  logic [IMAGE_WIDTH_W-1:0]   image_width_r, image_width_nxt;
  logic [IMAGE_HEIGHT_W-1:0]  image_height_r, image_height_nxt;
  logic [CHANNEL_COUNT_W-1:0] channel_count_r, channel_count_nxt;
  logic                       cfg_wr, restart;
  logic [31:0]                iw32, ih32, ic32;
  logic [WW-1:0]              w_eff;
  logic [HW-1:0]              h_eff;
  logic [CEW-1:0]             c_eff;

  q_wr_t                      q_wr;
  desc_t                      q_head;
  logic                       q_valid, q_pop;
  logic [QUEUE_CNT_W-1:0]     q_count;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    image_width_nxt   = image_width_r;
    image_height_nxt  = image_height_r;
    channel_count_nxt = channel_count_r;
    restart           = 1'b0;
    if (cfg_wr) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_IMAGE_WIDTH: begin
          image_width_nxt = cfg_data[IMAGE_WIDTH_W-1:0];
          restart         = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          image_height_nxt = cfg_data[IMAGE_HEIGHT_W-1:0];
          restart          = 1'b1;
        end
        CFG_CHANNEL_COUNT: begin
          channel_count_nxt = cfg_data[CHANNEL_COUNT_W-1:0];
          restart           = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= IMAGE_WIDTH_W'(RST_IMAGE_WIDTH);
      image_height_r  <= IMAGE_HEIGHT_W'(RST_IMAGE_HEIGHT);
      channel_count_r <= CHANNEL_COUNT_W'(RST_CHANNEL_COUNT);
    end else begin
      image_width_r   <= image_width_nxt;
      image_height_r  <= image_height_nxt;
      channel_count_r <= channel_count_nxt;
    end
  end

  // Out-of-range settings are clamped to the minimum and maximum geometry.
  always_comb begin
    iw32 = 32'(image_width_r);
    ih32 = 32'(image_height_r);
    ic32 = 32'(channel_count_r);
    if (iw32 < 32'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else if (iw32 > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(iw32);
    end
    if (ih32 < 32'(MIN_DIM)) begin
      h_eff = HW'(MIN_DIM);
    end else if (ih32 > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(ih32);
    end
    if (ic32 < 32'(MIN_CHANNELS)) begin
      c_eff = CEW'(MIN_CHANNELS);
    end else if (ic32 > 32'(MAX_CHANNELS)) begin
      c_eff = CEW'(MAX_CHANNELS);
    end else begin
      c_eff = CEW'(ic32);
    end
  end

  iss_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_HEIGHT   (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .c_eff     (c_eff),
    .in_push   (in_push),
    .in_sample (in_sample),
    .in_full   (in_full),
    .q_count   (q_count),
    .q_wr      (q_wr)
  );

  iss_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .head  (q_head),
    .valid (q_valid),
    .count (q_count)
  );

  iss_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_value     (out_value),
    .out_row       (out_row),
    .out_index     (out_index),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last)
  );

endmodule

`default_nettype wire

>>> sv/iss_front.sv
// ----------------------------------------------------------------------------
// iss_front
// Position counters, line stores and neighbourhood gathering; classifies
// each beat and hands a descriptor to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "image_sharpen_3x3_cross_macros.svh"

module iss_front #(
  parameter int MAX_WIDTH    = iss_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = iss_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_HEIGHT   = iss_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    restart,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]          w_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]         h_eff,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]       c_eff,
  input  logic                                    in_push,
  input  logic [iss_pkg::SAMPLE_W-1:0]            in_sample,
  output logic                                    in_full,
  input  logic [iss_pkg::QUEUE_CNT_W-1:0]         q_count,
  output iss_pkg::q_wr_t                          q_wr
);
  import iss_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CEW   = $clog2(MAX_CHANNELS + 1);

  logic [CW-1:0] ch_r, ch_nxt;
  logic [PW-1:0] pix_r, pix_nxt;
  logic [AW-1:0] s_r, s_nxt;
  logic [RW-1:0] r_r, r_nxt;

  logic          accept;
  logic          last_ch, last_pix, last_row, interior, has_res;
  logic [AW:0]   rt_sum;
  logic [AW-1:0] rt_addr;
  logic [31:0]   row_m1, idx32;

  logic [SAMPLE_W-1:0] older_mem [DEPTH];
  logic [SAMPLE_W-1:0] newer_mem [DEPTH];

  logic                v1_r;
  logic [AW-1:0]       s1_addr_r;
  logic [SAMPLE_W-1:0] s1_dn_r;
  logic                s1_has_res_r, s1_interior_r, s1_last_row_r, s1_fend_r;
  logic [POS_W-1:0]    s1_row_r, s1_idx_r;
  logic [SAMPLE_W-1:0] rd_mid_r, rd_rt_r, rd_up_r;
  logic [SAMPLE_W-1:0] shl_r [MAX_CHANNELS];
  logic [CEW-1:0]      c_m1;
  logic [CW-1:0]       c_idx;

  // Beats in stage one are counted as if already committed to the queue.
  assign in_full = (({1'b0, q_count} + (QUEUE_CNT_W+1)'(v1_r)) >=
                    (QUEUE_CNT_W+1)'(QUEUE_DEPTH));
  assign accept  = in_push && !in_full;

  always_comb begin
    last_ch  = (32'(ch_r) == 32'(c_eff) - 32'd1);
    last_pix = (32'(pix_r) == 32'(w_eff) - 32'd1);
    last_row = (32'(r_r) == 32'(h_eff) - 32'd1);
    interior = (pix_r != '0) && (32'(pix_r) <= 32'(w_eff) - 32'd2);
    has_res  = (r_r != RW'(1));
    rt_sum   = {1'b0, s_r} + (AW+1)'(c_eff);
    rt_addr  = (rt_sum < (AW+1)'(DEPTH)) ? rt_sum[AW-1:0] : '0;
    row_m1   = 32'(r_r) - 32'd1;
    idx32    = 32'(s_r);

    ch_nxt  = ch_r;
    pix_nxt = pix_r;
    s_nxt   = s_r;
    r_nxt   = r_r;
    if (restart) begin
      ch_nxt  = '0;
      pix_nxt = '0;
      s_nxt   = '0;
      r_nxt   = '0;
    end else if (accept) begin
      if (last_ch) begin
        ch_nxt = '0;
        if (last_pix) begin
          pix_nxt = '0;
          s_nxt   = '0;
          r_nxt   = last_row ? '0 : r_r + RW'(1);
        end else begin
          pix_nxt = pix_r + PW'(1);
          s_nxt   = s_r + AW'(1);
        end
      end else begin
        ch_nxt = ch_r + CW'(1);
        s_nxt  = s_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r  <= '0;
      pix_r <= '0;
      s_r   <= '0;
      r_r   <= '0;
      v1_r  <= 1'b0;
    end else begin
      ch_r  <= ch_nxt;
      pix_r <= pix_nxt;
      s_r   <= s_nxt;
      r_r   <= r_nxt;
      v1_r  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r     <= s_r;
      s1_dn_r       <= in_sample;
      s1_has_res_r  <= has_res;
      s1_interior_r <= interior && (r_r != '0);
      s1_last_row_r <= last_row;
      s1_fend_r     <= last_ch && last_pix;
      s1_row_r      <= (r_r == '0) ? '0 : row_m1[POS_W-1:0];
      s1_idx_r      <= idx32[POS_W-1:0];
    end
  end

  // The newer store is read before it is overwritten at the same address.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_mid_r       <= newer_mem[s_r];
      rd_rt_r        <= newer_mem[rt_addr];
      newer_mem[s_r] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_up_r <= older_mem[s_r];
    end
    if (v1_r) begin
      older_mem[s1_addr_r] <= rd_mid_r;
    end
  end

  // The left neighbour is the centre sample of the beat one pixel earlier.
  always_ff @(posedge clk) begin
    if (v1_r) begin
      shl_r[0] <= rd_mid_r;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        shl_r[i] <= shl_r[i-1];
      end
    end
  end

  always_comb begin
    c_m1  = c_eff - CEW'(1);
    c_idx = CW'(c_m1);
    q_wr.push           = v1_r && s1_has_res_r;
    q_wr.desc.up        = rd_up_r;
    q_wr.desc.mid       = rd_mid_r;
    q_wr.desc.lf        = shl_r[c_idx];
    q_wr.desc.rt        = rd_rt_r;
    q_wr.desc.dn        = s1_dn_r;
    q_wr.desc.interior  = s1_interior_r;
    q_wr.desc.last_row  = s1_last_row_r;
    q_wr.desc.frame_end = s1_fend_r;
    q_wr.desc.row       = s1_row_r;
    q_wr.desc.index     = s1_idx_r;
  end

  `ISS_ASSERT_NEXT(a_front_push_follows, accept && has_res, q_wr.push)

endmodule

`default_nettype wire

>>> sv/iss_queue.sv
// ----------------------------------------------------------------------------
// iss_queue
// Short descriptor queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "image_sharpen_3x3_cross_macros.svh"

module iss_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  iss_pkg::q_wr_t                  q_wr,
  input  logic                            pop,
  output iss_pkg::desc_t                  head,
  output logic                            valid,
  output logic [iss_pkg::QUEUE_CNT_W-1:0] count
);
  import iss_pkg::*;

  desc_t                  slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   push;

  assign push  = q_wr.push;
  assign head  = slot_r[rd_ptr_r];
  assign valid = (count_r != '0);
  assign count = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                   wr_ptr_r + QUEUE_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                   rd_ptr_r + QUEUE_PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QUEUE_CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= q_wr.desc;
    end
  end

  `ISS_ASSERT_IMPLY(a_queue_no_overflow, count_r == QUEUE_CNT_W'(QUEUE_DEPTH), !push)
  `ISS_ASSERT_IMPLY(a_queue_no_underflow, pop, count_r != '0)

endmodule

`default_nettype wire

>>> sv/iss_back.sv
// ----------------------------------------------------------------------------
// iss_back
// Evaluates the cross kernel, clamps it and drives the result register,
// splitting a last-row descriptor into its two results.
// ----------------------------------------------------------------------------
`default_nettype none
`include "image_sharpen_3x3_cross_macros.svh"

module iss_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  iss_pkg::desc_t               q_head,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [iss_pkg::SAMPLE_W-1:0] out_value,
  output logic [iss_pkg::POS_W-1:0]    out_row,
  output logic [iss_pkg::POS_W-1:0]    out_index,
  output logic                         out_frame_end,
  output logic                         out_run_last
);
  import iss_pkg::*;

  logic                out_valid_r, out_valid_nxt;
  logic                phase_r, phase_nxt;
  logic [SAMPLE_W-1:0] value_r;
  logic [POS_W-1:0]    row_r, index_r;
  logic                fend_r, run_last_r;

  logic                load, take;
  logic [11:0]         mid5, nsum;
  logic signed [11:0]  diff;
  logic [SAMPLE_W-1:0] kval;
  logic [SAMPLE_W-1:0] value_d;
  logic [POS_W-1:0]    row_d;
  logic                fend_d, run_last_d;

  assign out_empty     = !out_valid_r;
  assign out_value     = value_r;
  assign out_row       = row_r;
  assign out_index     = index_r;
  assign out_frame_end = fend_r;
  assign out_run_last  = run_last_r;

  always_comb begin
    mid5 = {2'b00, q_head.mid, 2'b00} + {4'b0000, q_head.mid};
    nsum = {4'b0000, q_head.lf} + {4'b0000, q_head.rt} +
           {4'b0000, q_head.up} + {4'b0000, q_head.dn};
    diff = $signed(mid5) - $signed(nsum);
    if (!q_head.interior || diff < 12'sd0) begin
      kval = '0;
    end else if (diff > 12'sd255) begin
      kval = '1;
    end else begin
      kval = diff[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    load          = !out_valid_r || out_pop;
    take          = 1'b0;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    value_d       = kval;
    row_d         = q_head.row;
    fend_d        = 1'b0;
    run_last_d    = !q_head.last_row;
    if (load) begin
      out_valid_nxt = 1'b0;
      if (phase_r) begin
        // Second result of a last-row beat: the zero for that row itself.
        take          = 1'b1;
        q_pop         = 1'b1;
        phase_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
        value_d       = '0;
        row_d         = q_head.row + POS_W'(1);
        fend_d        = q_head.frame_end;
        run_last_d    = 1'b1;
      end else if (q_valid) begin
        take          = 1'b1;
        out_valid_nxt = 1'b1;
        phase_nxt     = q_head.last_row;
        q_pop         = !q_head.last_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      value_r    <= value_d;
      row_r      <= row_d;
      index_r    <= q_head.index;
      fend_r     <= fend_d;
      run_last_r <= run_last_d;
    end
  end

  `ISS_ASSERT_IMPLY(a_back_split_holds, phase_r, out_valid_r && !run_last_r && q_valid)

endmodule

`default_nettype wire

>>> verif/tb_image_sharpen_3x3_cross.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_image_sharpen_3x3_cross
// Self-checking bench for the 3x3 cross sharpening block. Raw samples are
// streamed in raster order over the in_ queue while a behavioural copy of the
// filter works out every result. Each popped result is compared field by
// field. Directed frames cover the reset geometry, both ends of the clamp,
// a write to an unlisted register and the largest geometries. Random frames
// with random geometry then follow under several sender and receiver idle
// patterns.
// ----------------------------------------------------------------------------
module tb_image_sharpen_3x3_cross;
  import iss_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int MAX_REPORTS    = 40;
  localparam int LINE_DEPTH     = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
  localparam int ITEMS_PER_MODE = 220;
  localparam int PARTIAL_MAX    = 120;
  localparam int CLAMP_BEATS    = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNLISTED = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    index;
    logic                frame_end;
    logic                run_last;
  } sharp_result_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_push   = 1'b0;
  logic [SAMPLE_W-1:0]    in_sample = '0;
  logic                   out_pop   = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  logic                in_full;
  logic                out_empty;
  logic [SAMPLE_W-1:0] out_value;
  logic [POS_W-1:0]    out_row;
  logic [POS_W-1:0]    out_index;
  logic                out_frame_end;
  logic                out_run_last;
  logic                cfg_ready;

  image_sharpen_3x3_cross i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_sample     (in_sample),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_value     (out_value),
    .out_row       (out_row),
    .out_index     (out_index),
    .out_frame_end (out_frame_end),
    .out_run_last  (out_run_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_image_sharpen_3x3_cross: done, errors");
    $finish;
  end

  // Shadow copy of the geometry registers and of the filter state.
  logic [IMAGE_WIDTH_W-1:0]   geo_width    = IMAGE_WIDTH_W'(RST_IMAGE_WIDTH);
  logic [IMAGE_HEIGHT_W-1:0]  geo_height   = IMAGE_HEIGHT_W'(RST_IMAGE_HEIGHT);
  logic [CHANNEL_COUNT_W-1:0] geo_channels = CHANNEL_COUNT_W'(RST_CHANNEL_COUNT);
  int                         cur_row      = 0;
  int                         cur_sample   = 0;
  bit [SAMPLE_W-1:0]          older_px [LINE_DEPTH];
  bit [SAMPLE_W-1:0]          newer_px [LINE_DEPTH];

  sharp_result_t sharp_expected [$];
  int            error_count   = 0;
  int            send_idle_pct = 0;
  int            pop_stall_pct = 0;

  function automatic int clamp_int(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int eff_width();
    return clamp_int(int'(geo_width), MIN_DIM, DEF_MAX_WIDTH);
  endfunction

  function automatic int eff_height();
    return clamp_int(int'(geo_height), MIN_DIM, DEF_MAX_HEIGHT);
  endfunction

  function automatic int eff_channels();
    return clamp_int(int'(geo_channels), MIN_CHANNELS, DEF_MAX_CHANNELS);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom_range(255));
    endcase
  endfunction

  // Works out the results caused by one accepted beat and advances the
  // shadow counters and line stores.
  task automatic predict_sharpen(input logic [SAMPLE_W-1:0] smp);
    int            w, h, c, spr, r, s, p, t;
    bit            last_row;
    sharp_result_t res;
    w   = eff_width();
    h   = eff_height();
    c   = eff_channels();
    spr = w * c;
    r   = cur_row;
    s   = cur_sample;
    if (s >= spr) s = 0;
    if (r >= h) r = 0;
    last_row = (r == h - 1);
    if (r == 0) begin
      res = '{value: '0, row: '0, index: POS_W'(s), frame_end: 1'b0, run_last: 1'b1};
      sharp_expected.push_back(res);
    end else if (r >= 2) begin
      p = s / c;
      res.value = '0;
      // Only interior pixel columns are filtered; borders give zero.
      if (p >= 1 && p <= w - 2) begin
        t = 5 * int'(newer_px[s]) - int'(older_px[s - c]) - int'(newer_px[s + c])
            - int'(older_px[s]) - int'(smp);
        res.value = SAMPLE_W'(clamp_int(t, 0, 255));
      end
      res.row       = POS_W'(r - 1);
      res.index     = POS_W'(s);
      res.frame_end = 1'b0;
      res.run_last  = !last_row;
      sharp_expected.push_back(res);
      if (last_row) begin
        res = '{value: '0, row: POS_W'(r), index: POS_W'(s),
                frame_end: (s == spr - 1), run_last: 1'b1};
        sharp_expected.push_back(res);
      end
    end
    older_px[s] = newer_px[s];
    newer_px[s] = smp;
    s++;
    if (s >= spr) begin
      s = 0;
      r++;
      if (r >= h) r = 0;
    end
    cur_sample = s;
    cur_row    = r;
  endtask

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("MISMATCH @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_sharpened();
    sharp_result_t want;
    if (sharp_expected.size() == 0) begin
      report_mismatch($sformatf("unexpected result row %0d index %0d", out_row, out_index));
      return;
    end
    want = sharp_expected.pop_front();
    if (out_value !== want.value)
      report_mismatch($sformatf("value row %0d index %0d: got %0d, expected %0d",
                                want.row, want.index, out_value, want.value));
    if (out_row !== want.row)
      report_mismatch($sformatf("row at index %0d: got %0d, expected %0d",
                                want.index, out_row, want.row));
    if (out_index !== want.index)
      report_mismatch($sformatf("index row %0d: got %0d, expected %0d",
                                want.row, out_index, want.index));
    if (out_frame_end !== want.frame_end)
      report_mismatch($sformatf("frame_end row %0d index %0d: got %0b, expected %0b",
                                want.row, want.index, out_frame_end, want.frame_end));
    if (out_run_last !== want.run_last)
      report_mismatch($sformatf("run_last row %0d index %0d: got %0b, expected %0b",
                                want.row, want.index, out_run_last, want.run_last));
  endtask

  // Receiver: pop is decided at the rising edge, the beat is checked at the
  // falling edge when everything on the result ports has settled.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_pop && !out_empty) check_sharpened();
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push   <= 1'b1;
    in_sample <= smp;
    do begin
      @(negedge clk);
      taken = !in_full;
      if (taken) predict_sharpen(smp);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_samples(input int count);
    repeat (count) push_sample(pick_sample());
  endtask

  // Lets every outstanding result drain, then allows for a beat still in
  // flight that causes no result.
  task automatic wait_pipeline_idle();
    in_push <= 1'b0;
    while (sharp_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      if (taken) begin
        case (idx)
          CFG_IMAGE_WIDTH:   geo_width    = data[IMAGE_WIDTH_W-1:0];
          CFG_IMAGE_HEIGHT:  geo_height   = data[IMAGE_HEIGHT_W-1:0];
          CFG_CHANNEL_COUNT: geo_channels = data[CHANNEL_COUNT_W-1:0];
          default: ;
        endcase
        // A listed register restarts the frame; the line stores are kept.
        if (idx != CFG_UNLISTED) begin
          cur_row    = 0;
          cur_sample = 0;
        end
      end
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w,
                              input logic [CFG_DATA_W-1:0] h,
                              input logic [CFG_DATA_W-1:0] c);
    wait_pipeline_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_CHANNEL_COUNT, c);
  endtask

  // A few beats at the reset geometry give the row-zero results.
  task automatic test_reset_values();
    send_samples(6);
  endtask

  // A lone bright centre saturates high, a lone dark centre saturates low.
  task automatic test_clamp_limits();
    set_geometry(3, 3, 1);
    for (int i = 0; i < 9; i++) push_sample((i == 4) ? 8'hFF : 8'h00);
    for (int i = 0; i < 9; i++) push_sample((i == 4) ? 8'h00 : 8'hFF);
  endtask

  // A write to the spare index must not restart the frame.
  task automatic test_unlisted_register();
    set_geometry(3, 3, 1);
    send_samples(4);
    wait_pipeline_idle();
    write_reg(CFG_UNLISTED, '1);
    send_samples(5);
  endtask

  // Out-of-range register values clamp to the size limits: all-ones writes give
  // the largest width, channels or height, with the ignored upper data bits set,
  // and zeros the smallest width and channel count. Only the frame starts are
  // sent; the narrow frame runs past its third row, the last one at height 3.
  task automatic test_largest_geometry();
    send_idle_pct = 0;
    pop_stall_pct = 0;
    set_geometry('1, 3, '1);
    send_samples(CLAMP_BEATS);
    set_geometry(DEF_MAX_WIDTH, 3, 1);
    send_samples(CLAMP_BEATS);
    set_geometry(0, '1, 0);
    send_samples(CLAMP_BEATS);
  endtask

  task automatic test_random_stream(input int send_pct, input int stall_pct);
    int                    sent, frame_len, count;
    logic [CFG_DATA_W-1:0] w_raw, h_raw, c_raw;
    send_idle_pct = send_pct;
    pop_stall_pct = stall_pct;
    sent = 0;
    while (sent < ITEMS_PER_MODE) begin
      if ($urandom_range(15) == 0) w_raw = CFG_DATA_W'($urandom_range(1025, 8191));
      else if ($urandom_range(7) == 0) w_raw = CFG_DATA_W'($urandom_range(2));
      else w_raw = CFG_DATA_W'($urandom_range(3, 8));
      if ($urandom_range(15) == 0) h_raw = CFG_DATA_W'($urandom_range(4097, 8191));
      else if ($urandom_range(7) == 0) h_raw = CFG_DATA_W'($urandom_range(2));
      else h_raw = CFG_DATA_W'($urandom_range(3, 6));
      c_raw = CFG_DATA_W'($urandom_range(8191));
      set_geometry(w_raw, h_raw, c_raw);
      frame_len = eff_width() * eff_channels() * eff_height();
      // Mostly whole frames, sometimes two back to back, and now and then a
      // frame cut short by the next register write.
      if (frame_len > 400 || $urandom_range(7) == 0)
        count = $urandom_range(1, clamp_int(frame_len - 1, 1, PARTIAL_MAX));
      else if ($urandom_range(3) == 0)
        count = 2 * frame_len;
      else
        count = frame_len;
      send_samples(count);
      sent += count;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_clamp_limits();
    test_unlisted_register();
    test_largest_geometry();
    test_random_stream(0, 0);
    test_random_stream(54, 0);
    test_random_stream(0, 54);
    test_random_stream(34, 34);
    send_idle_pct = 0;
    pop_stall_pct = 0;
    wait_pipeline_idle();
    if (error_count == 0) begin
      $display("tb_image_sharpen_3x3_cross: done, clean");
    end else begin
      $display("tb_image_sharpen_3x3_cross: done, errors");
    end
    $finish;
  end

endmodule
